@@ design/assert_macros.svh @@
// Assertion helpers used by the queue datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk.
`define TCPQ_ASSERT_AT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check on every rising edge of clk, off while the active-low reset is held.
`define TCPQ_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ design/tcpq_pkg.sv @@
`default_nettype none

package tcpq_pkg;

    localparam int unsigned QUEUE_DEPTH   = 16;
    localparam int unsigned IDX_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned RAM_AW        = IDX_W + 1;
    localparam int unsigned RAM_DEPTH     = 1 << RAM_AW;
    localparam int unsigned ID_W          = 16;
    localparam int unsigned PRIO_W        = 15;
    localparam int unsigned ENTRY_W       = ID_W + PRIO_W;
    localparam logic [PRIO_W-1:0] THRESHOLD_RESET = PRIO_W'(150);

    typedef enum logic [2:0] {
        ST_HIGH  = 3'd0,
        ST_LOW   = 3'd1,
        ST_NEG   = 3'd2,
        ST_FULL  = 3'd3,
        ST_DEQ   = 3'd4,
        ST_EMPTY = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_HEAD,
        S_WALK,
        S_DEQ,
        S_RES
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    rd_head;
        logic    walk_start;
        logic    step;
        logic    ins_at;
        logic    ins_head;
        logic    deq;
        logic    res_set;
        logic    res_take_rdata;
        t_status res_code;
        logic    push;
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic cmd_deq;
        logic neg;
        logic sel_high;
        logic full;
        logic empty;
        logic ge_head;
        logic rd_lt;
        logic walk_zero;
        logic out_free;
    } t_stat;

    // Map a position in the queue to a slot of its circular buffer.
    function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] head,
                                                  input logic [IDX_W:0]   pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + pos;
        if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ design/two_class_priority_job_queue.sv @@
`default_nettype none

// Two-class priority job queue.
// Input channel (i_valid / o_stall): i_cmd 0 submits job i_job_id with signed
// priority i_job_priority, i_cmd 1 asks for a dequeue. Output channel
// (o_valid / i_stall): exactly one result transaction per input transaction,
// carrying o_status, o_out_id, o_out_priority and o_from_high.
// Jobs at or above the threshold (i_cfg_we / i_cfg_wdata, reset 150) go to the
// high queue, other non-negative jobs to the low one. Both queues live in one
// RAM as circular buffers kept in descending priority order.
// One item is in flight at a time. Rejects, full queues, empty-queue inserts
// and dequeues with both queues empty go from S_DECIDE straight to S_RES;
// head inserts and dequeues pass S_DECIDE, then S_HEAD or S_DEQ, then S_RES.
// A sorted insert walks back from the tail one entry per cycle over the single
// RAM port pair, shifting smaller entries down until its slot is found.
// o_stall drops as the result enters the output register.
// While the receiver stalls, the result holds and a finished next result waits
// in the result register of the datapath.
// Reset empties both queues and restores the threshold; no clearing pass.
module two_class_priority_job_queue (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [tcpq_pkg::PRIO_W-1:0] i_cfg_wdata,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_cmd,
    input  wire logic [tcpq_pkg::ID_W-1:0]   i_job_id,
    input  wire logic signed [15:0]          i_job_priority,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [2:0]                       o_status,
    output logic [tcpq_pkg::ID_W-1:0]        o_out_id,
    output logic [tcpq_pkg::PRIO_W-1:0]      o_out_priority,
    output logic                             o_from_high
);

    tcpq_pkg::t_ctrl w_cmd;
    tcpq_pkg::t_stat w_stat;

    tcpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_stall (o_stall)
    );

    tcpq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd_bit      (i_cmd),
        .i_job_id       (i_job_id),
        .i_job_priority (i_job_priority),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_from_high    (o_from_high)
    );

endmodule

`default_nettype wire

@@ design/tcpq_ram.sv @@
`default_nettype none

module tcpq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/tcpq_ctrl.sv @@
`default_nettype none

module tcpq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire tcpq_pkg::t_stat i_stat,
    output tcpq_pkg::t_ctrl     o_cmd,
    output logic                o_stall
);

    tcpq_pkg::t_state r_state;
    tcpq_pkg::t_state n_state;
    tcpq_pkg::t_status w_put_code;

    assign w_put_code = i_stat.sel_high ? tcpq_pkg::ST_HIGH : tcpq_pkg::ST_LOW;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcpq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tcpq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = tcpq_pkg::S_DECIDE;
                end
            end
            tcpq_pkg::S_DECIDE: begin
                if (i_stat.cmd_deq) begin
                    n_state = i_stat.empty ? tcpq_pkg::S_RES : tcpq_pkg::S_DEQ;
                end else if (i_stat.neg || i_stat.full || i_stat.empty) begin
                    n_state = tcpq_pkg::S_RES;
                end else begin
                    n_state = tcpq_pkg::S_HEAD;
                end
            end
            tcpq_pkg::S_HEAD: begin
                n_state = i_stat.ge_head ? tcpq_pkg::S_RES : tcpq_pkg::S_WALK;
            end
            tcpq_pkg::S_WALK: begin
                if (i_stat.walk_zero || !i_stat.rd_lt) begin
                    n_state = tcpq_pkg::S_RES;
                end
            end
            tcpq_pkg::S_DEQ: begin
                n_state = tcpq_pkg::S_RES;
            end
            tcpq_pkg::S_RES: begin
                if (i_stat.out_free) begin
                    n_state = tcpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcpq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.res_code = tcpq_pkg::ST_HIGH;
        o_stall        = (r_state != tcpq_pkg::S_IDLE);
        case (r_state)
            tcpq_pkg::S_IDLE: begin
                o_cmd.load = i_valid;
            end
            tcpq_pkg::S_DECIDE: begin
                if (i_stat.cmd_deq) begin
                    if (i_stat.empty) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = tcpq_pkg::ST_EMPTY;
                    end else begin
                        o_cmd.rd_head = 1'b1;
                    end
                end else if (i_stat.neg) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = tcpq_pkg::ST_NEG;
                end else if (i_stat.full) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = tcpq_pkg::ST_FULL;
                end else if (i_stat.empty) begin
                    o_cmd.ins_head = 1'b1;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = w_put_code;
                end else begin
                    o_cmd.rd_head = 1'b1;
                end
            end
            tcpq_pkg::S_HEAD: begin
                if (i_stat.ge_head) begin
                    o_cmd.ins_head = 1'b1;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = w_put_code;
                end else begin
                    o_cmd.walk_start = 1'b1;
                end
            end
            tcpq_pkg::S_WALK: begin
                // shift smaller entries down until the slot is found
                if (i_stat.walk_zero || !i_stat.rd_lt) begin
                    o_cmd.ins_at   = 1'b1;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = w_put_code;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            tcpq_pkg::S_DEQ: begin
                o_cmd.deq            = 1'b1;
                o_cmd.res_set        = 1'b1;
                o_cmd.res_take_rdata = 1'b1;
                o_cmd.res_code       = tcpq_pkg::ST_DEQ;
            end
            tcpq_pkg::S_RES: begin
                o_cmd.push = i_stat.out_free;
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/tcpq_dp.sv @@
`default_nettype none

`include "assert_macros.svh"

module tcpq_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tcpq_pkg::t_ctrl               i_cmd,
    output tcpq_pkg::t_stat                    o_stat,
    input  wire logic                          i_cfg_we,
    input  wire logic [tcpq_pkg::PRIO_W-1:0]   i_cfg_wdata,
    input  wire logic                          i_cmd_bit,
    input  wire logic [tcpq_pkg::ID_W-1:0]     i_job_id,
    input  wire logic signed [15:0]            i_job_priority,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output logic [2:0]                         o_status,
    output logic [tcpq_pkg::ID_W-1:0]         o_out_id,
    output logic [tcpq_pkg::PRIO_W-1:0]       o_out_priority,
    output logic                               o_from_high
);

    localparam logic [tcpq_pkg::CNT_W-1:0] CNT_FULL = tcpq_pkg::CNT_W'(tcpq_pkg::QUEUE_DEPTH);

    logic [tcpq_pkg::PRIO_W-1:0] r_thr;
    logic [tcpq_pkg::IDX_W-1:0]  r_head  [2];
    logic [tcpq_pkg::CNT_W-1:0]  r_count [2];
    logic                        r_cmd_deq;
    logic                        r_neg;
    logic                        r_sel;
    logic [tcpq_pkg::ID_W-1:0]   r_id;
    logic [tcpq_pkg::PRIO_W-1:0] r_prio;
    logic [tcpq_pkg::IDX_W-1:0]  r_walk;

    tcpq_pkg::t_status           r_res_status;
    logic [tcpq_pkg::ID_W-1:0]   r_res_id;
    logic [tcpq_pkg::PRIO_W-1:0] r_res_prio;
    logic                        r_res_high;

    logic                        r_o_valid;
    tcpq_pkg::t_status           r_o_status;
    logic [tcpq_pkg::ID_W-1:0]   r_o_id;
    logic [tcpq_pkg::PRIO_W-1:0] r_o_prio;
    logic                        r_o_high;

    logic [tcpq_pkg::IDX_W-1:0]  w_head;
    logic [tcpq_pkg::CNT_W-1:0]  w_count;
    logic [tcpq_pkg::IDX_W-1:0]  w_head_dec;
    logic [tcpq_pkg::IDX_W-1:0]  w_head_inc;
    logic [tcpq_pkg::IDX_W:0]    w_pos_last;
    logic [tcpq_pkg::IDX_W:0]    w_pos_next;
    logic [tcpq_pkg::IDX_W:0]    w_pos_prev;
    logic                        w_full;
    logic                        w_empty;
    logic                        w_out_free;
    logic                        w_load_sel;
    tcpq_pkg::t_entry            w_new;
    tcpq_pkg::t_entry            w_rdata;
    logic [tcpq_pkg::ENTRY_W-1:0] w_rdata_raw;
    logic                        w_re;
    logic [tcpq_pkg::RAM_AW-1:0] w_raddr;
    logic                        w_we;
    logic [tcpq_pkg::RAM_AW-1:0] w_waddr;
    tcpq_pkg::t_entry            w_wdata;

    assign w_head     = r_head[r_sel];
    assign w_count    = r_count[r_sel];
    assign w_full     = (w_count == CNT_FULL);
    assign w_empty    = (w_count == '0);
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_head_dec = (w_head == '0) ? tcpq_pkg::IDX_W'(tcpq_pkg::QUEUE_DEPTH - 1)
                                       : w_head - tcpq_pkg::IDX_W'(1);
    assign w_head_inc = (w_head == tcpq_pkg::IDX_W'(tcpq_pkg::QUEUE_DEPTH - 1))
                        ? '0 : w_head + tcpq_pkg::IDX_W'(1);
    assign w_pos_last = (tcpq_pkg::IDX_W+1)'(w_count - tcpq_pkg::CNT_W'(1));
    assign w_pos_next = {1'b0, r_walk} + (tcpq_pkg::IDX_W+1)'(1);
    assign w_pos_prev = {1'b0, r_walk} - (tcpq_pkg::IDX_W+1)'(1);
    assign w_new      = '{id: r_id, prio: r_prio};
    assign w_rdata    = tcpq_pkg::t_entry'(w_rdata_raw);

    // dequeue picks the high queue whenever it holds anything
    assign w_load_sel = i_cmd_bit ? (r_count[1] != '0)
                                  : (!i_job_priority[15] && (i_job_priority[14:0] >= r_thr));

    always_comb begin
        w_re    = i_cmd.rd_head || i_cmd.walk_start || i_cmd.step;
        w_raddr = {r_sel, w_head};
        if (i_cmd.walk_start) begin
            w_raddr = {r_sel, tcpq_pkg::phys_idx(w_head, w_pos_last)};
        end else if (i_cmd.step) begin
            w_raddr = {r_sel, tcpq_pkg::phys_idx(w_head, w_pos_prev)};
        end
    end

    always_comb begin
        w_we    = i_cmd.step || i_cmd.ins_at || i_cmd.ins_head;
        w_waddr = {r_sel, tcpq_pkg::phys_idx(w_head, w_pos_next)};
        w_wdata = i_cmd.step ? w_rdata : w_new;
        if (i_cmd.ins_head) begin
            w_waddr = {r_sel, w_head_dec};
        end
    end

    tcpq_ram #(
        .WIDTH (tcpq_pkg::ENTRY_W),
        .DEPTH (tcpq_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= tcpq_pkg::THRESHOLD_RESET;
            r_head[0]  <= '0;
            r_head[1]  <= '0;
            r_count[0] <= '0;
            r_count[1] <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (i_cmd.ins_head) begin
                r_head[r_sel] <= w_head_dec;
            end else if (i_cmd.deq) begin
                r_head[r_sel] <= w_head_inc;
            end
            if (i_cmd.ins_head || i_cmd.ins_at) begin
                r_count[r_sel] <= w_count + tcpq_pkg::CNT_W'(1);
            end else if (i_cmd.deq) begin
                r_count[r_sel] <= w_count - tcpq_pkg::CNT_W'(1);
            end
            if (i_cmd.push) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd_deq <= i_cmd_bit;
            r_neg     <= i_job_priority[15];
            r_sel     <= w_load_sel;
            r_id      <= i_job_id;
            r_prio    <= i_job_priority[14:0];
        end
        if (i_cmd.walk_start) begin
            r_walk <= tcpq_pkg::IDX_W'(w_pos_last);
        end else if (i_cmd.step) begin
            r_walk <= r_walk - tcpq_pkg::IDX_W'(1);
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_code;
            r_res_id     <= i_cmd.res_take_rdata ? w_rdata.id : '0;
            r_res_prio   <= i_cmd.res_take_rdata ? w_rdata.prio : '0;
            r_res_high   <= i_cmd.res_take_rdata && r_sel;
        end
        if (i_cmd.push) begin
            r_o_status <= r_res_status;
            r_o_id     <= r_res_id;
            r_o_prio   <= r_res_prio;
            r_o_high   <= r_res_high;
        end
    end

    always_comb begin
        o_stat.cmd_deq   = r_cmd_deq;
        o_stat.neg       = r_neg;
        o_stat.sel_high  = r_sel;
        o_stat.full      = w_full;
        o_stat.empty     = w_empty;
        o_stat.ge_head   = (r_prio >= w_rdata.prio);
        o_stat.rd_lt     = (w_rdata.prio < r_prio);
        o_stat.walk_zero = (r_walk == '0);
        o_stat.out_free  = w_out_free;
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_out_id       = r_o_id;
    assign o_out_priority = r_o_prio;
    assign o_from_high    = r_o_high;

    `TCPQ_ASSERT_RST(a_count_bound, i_clk, i_rst_n, (r_count[0] <= CNT_FULL) && (r_count[1] <= CNT_FULL), "queue count beyond depth")
    `TCPQ_ASSERT_RST(a_ins_not_full, i_clk, i_rst_n, (i_cmd.ins_at || i_cmd.ins_head) |-> !w_full, "insert into a full queue")
    `TCPQ_ASSERT_RST(a_deq_not_empty, i_clk, i_rst_n, i_cmd.deq |-> !w_empty, "dequeue from an empty queue")
    `TCPQ_ASSERT_RST(a_push_lands, i_clk, i_rst_n, (i_cmd.push && w_out_free) |=> r_o_valid, "result lost at the output register")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
module testbench;
    import tcpq_pkg::*;

    localparam logic CMD_SUBMIT   = 1'b0;
    localparam logic CMD_DEQUEUE  = 1'b1;
    localparam int   IDLE_PCT     = 38;
    localparam int   QUIET_LIMIT  = 2000;
    localparam int   RANDOM_ITEMS = 1650;
    localparam int   MAX_SHOWN    = 10;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic              high;
    } job_result_t;

    typedef struct packed {
        logic            cmd;
        logic [ID_W-1:0] id;
        logic [15:0]     prio;
        logic            typed;
        job_result_t     want;
    } plan_row_t;

    localparam job_result_t R_EMPTY = '{ST_EMPTY, 16'h0, 15'h0, 1'b0};
    localparam job_result_t R_NEG   = '{ST_NEG,   16'h0, 15'h0, 1'b0};
    localparam job_result_t R_HIGH  = '{ST_HIGH,  16'h0, 15'h0, 1'b0};
    localparam job_result_t R_LOW   = '{ST_LOW,   16'h0, 15'h0, 1'b0};
    localparam job_result_t R_PRED  = '{ST_HIGH,  16'h0, 15'h0, 1'b0};

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_cfg_we       = 1'b0;
    logic [PRIO_W-1:0]        i_cfg_wdata    = '0;
    logic                     i_valid        = 1'b0;
    logic                     o_stall;
    logic                     i_cmd          = 1'b0;
    logic [ID_W-1:0]          i_job_id       = '0;
    logic signed [15:0]       i_job_priority = '0;
    logic                     o_valid;
    logic                     i_stall        = 1'b0;
    logic [2:0]               o_status;
    logic [ID_W-1:0]          o_out_id;
    logic [PRIO_W-1:0]        o_out_priority;
    logic                     o_from_high;

    // Directed sequence at the reset threshold of 150.
    plan_row_t plan [0:21] = '{
        '{CMD_DEQUEUE, 16'hFFFF, 16'hFFFF, 1'b1, R_EMPTY},
        '{CMD_SUBMIT,  16'hFFFF, 16'h8000, 1'b1, R_NEG},
        '{CMD_SUBMIT,  16'h0000, 16'hFFFF, 1'b1, R_NEG},
        '{CMD_SUBMIT,  16'h1234, 16'h7FFF, 1'b1, R_HIGH},
        '{CMD_SUBMIT,  16'h0001, 16'h0000, 1'b1, R_LOW},
        '{CMD_SUBMIT,  16'h0002, 16'd149,  1'b1, R_LOW},
        '{CMD_SUBMIT,  16'h0003, 16'd150,  1'b1, R_HIGH},
        '{CMD_SUBMIT,  16'h0004, 16'd150,  1'b0, R_PRED},
        '{CMD_SUBMIT,  16'h0005, 16'h7FFF, 1'b0, R_PRED},
        '{CMD_SUBMIT,  16'h0006, 16'd149,  1'b0, R_PRED},
        '{CMD_SUBMIT,  16'h0007, 16'd1000, 1'b0, R_PRED},
        '{CMD_SUBMIT,  16'h5555, 16'h4000, 1'b0, R_PRED},
        '{CMD_DEQUEUE, 16'h0000, 16'h0000, 1'b0, R_PRED},
        '{CMD_DEQUEUE, 16'hFFFF, 16'hFFFF, 1'b0, R_PRED},
        '{CMD_DEQUEUE, 16'hAAAA, 16'h5555, 1'b0, R_PRED},
        '{CMD_DEQUEUE, 16'h0000, 16'h8000, 1'b0, R_PRED},
        '{CMD_DEQUEUE, 16'h0000, 16'h0000, 1'b0, R_PRED},
        '{CMD_DEQUEUE, 16'h0000, 16'h0000, 1'b0, R_PRED},
        '{CMD_DEQUEUE, 16'hFFFF, 16'hFFFF, 1'b0, R_PRED},
        '{CMD_DEQUEUE, 16'h0000, 16'h0000, 1'b0, R_PRED},
        '{CMD_DEQUEUE, 16'h0000, 16'h0000, 1'b0, R_PRED},
        '{CMD_DEQUEUE, 16'h0000, 16'h0000, 1'b1, R_EMPTY}
    };

    t_entry            hi_jobs[$];
    t_entry            lo_jobs[$];
    logic [PRIO_W-1:0] threshold_q = THRESHOLD_RESET;
    job_result_t       awaited_results[$];
    bit                want_typed = 1'b0;
    job_result_t       want_res   = '0;
    bit                steady     = 1'b0;
    int                errors     = 0;
    int                n_in       = 0;
    int                n_out      = 0;
    int                n_cfg      = 0;
    int                quiet      = 0;
    int                tally [6]  = '{default: 0};

    two_class_priority_job_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_job_id       (i_job_id),
        .i_job_priority (i_job_priority),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_from_high    (o_from_high)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Head slot for a job at least as urgent as the head, else after all equal or higher.
    function automatic int unsigned sorted_slot(t_entry q[$], logic [PRIO_W-1:0] p);
        int unsigned pos;
        if (q.size() == 0 || p >= q[0].prio) begin
            return 0;
        end
        pos = 1;
        while (pos < q.size() && p <= q[pos].prio) begin
            pos++;
        end
        return pos;
    endfunction

    function automatic job_result_t schedule_job(logic cmd, logic [ID_W-1:0] id,
                                                 logic [15:0] raw);
        job_result_t r;
        t_entry      e;
        r      = '0;
        e.id   = id;
        e.prio = raw[PRIO_W-1:0];
        if (cmd == CMD_SUBMIT) begin
            if (raw[15]) begin
                r.status = ST_NEG;
            end else if (e.prio >= threshold_q) begin
                if (hi_jobs.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    hi_jobs.insert(sorted_slot(hi_jobs, e.prio), e);
                    r.status = ST_HIGH;
                end
            end else begin
                if (lo_jobs.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    lo_jobs.insert(sorted_slot(lo_jobs, e.prio), e);
                    r.status = ST_LOW;
                end
            end
        end else if (hi_jobs.size() != 0) begin
            e        = hi_jobs.pop_front();
            r.status = ST_DEQ;
            r.id     = e.id;
            r.prio   = e.prio;
            r.high   = 1'b1;
        end else if (lo_jobs.size() != 0) begin
            e        = lo_jobs.pop_front();
            r.status = ST_DEQ;
            r.id     = e.id;
            r.prio   = e.prio;
        end else begin
            r.status = ST_EMPTY;
        end
        return r;
    endfunction

    task automatic report_error(input string what);
        errors++;
        if (errors <= MAX_SHOWN) begin
            $display("mismatch: %s", what);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        job_result_t exp_r;
        if (!i_rst_n) begin
            hi_jobs.delete();
            lo_jobs.delete();
            awaited_results.delete();
            threshold_q = THRESHOLD_RESET;
        end else begin
            if (i_cfg_we) begin
                threshold_q = i_cfg_wdata;
                n_cfg++;
            end
            if (o_valid && !i_stall) begin
                n_out++;
                if (awaited_results.size() == 0) begin
                    report_error($sformatf("unexpected result status %0d id %h prio %0d high %b",
                                           o_status, o_out_id, o_out_priority, o_from_high));
                end else begin
                    exp_r = awaited_results.pop_front();
                    tally[exp_r.status]++;
                    if (o_status !== exp_r.status || o_out_id !== exp_r.id ||
                        o_out_priority !== exp_r.prio || o_from_high !== exp_r.high) begin
                        report_error($sformatf(
                            "result %0d expected %0d/%h/%0d/%b got %0d/%h/%0d/%b", n_out,
                            exp_r.status, exp_r.id, exp_r.prio, exp_r.high,
                            o_status, o_out_id, o_out_priority, o_from_high));
                    end
                end
            end
            // Predict after retiring, so a transaction never meets its own result.
            if (i_valid && !o_stall) begin
                n_in++;
                exp_r = schedule_job(i_cmd, i_job_id, i_job_priority);
                awaited_results.push_back(want_typed ? want_res : exp_r);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet);
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                             input logic [15:0] prio, input bit typed,
                             input job_result_t want);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_job_id       <= id;
        i_job_priority <= prio;
        want_typed     <= typed;
        want_res       <= want;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Drop valid and hold off until every result is back and the block is quiet.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (QUEUE_DEPTH + 8) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [PRIO_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Cluster priorities around the threshold and a few repeated values to force ties.
    function automatic logic [15:0] pick_priority(logic [PRIO_W-1:0] thr,
                                                  logic [PRIO_W-1:0] base_a,
                                                  logic [PRIO_W-1:0] base_b);
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            return {1'b1, 15'($urandom)};
        end
        if (sel < 25) begin
            return {1'b0, 15'($urandom)};
        end
        if (sel < 60) begin
            v = int'(thr) + int'($urandom_range(0, 6)) - 3;
        end else begin
            case ($urandom_range(0, 5))
                0: v = 0;
                1: v = 32767;
                2: v = int'(thr);
                3: v = int'(base_a);
                4: v = int'(base_b);
                default: v = int'(thr) - 1;
            endcase
        end
        if (v < 0) begin
            v = 0;
        end
        if (v > 32767) begin
            v = 32767;
        end
        return {1'b0, 15'(v)};
    endfunction

    initial begin : stimulus
        int                done_items;
        int                phase;
        int                quota;
        int                submit_pct;
        int                style;
        logic [PRIO_W-1:0] thr;
        logic [PRIO_W-1:0] base_a;
        logic [PRIO_W-1:0] base_b;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            send_item(plan[k].cmd, plan[k].id, plan[k].prio, plan[k].typed, plan[k].want);
        end

        done_items = 0;
        phase      = 0;
        while (done_items < RANDOM_ITEMS) begin
            case (phase % 6)
                0: thr = '0;
                1: thr = '1;
                2: thr = THRESHOLD_RESET;
                3: thr = PRIO_W'(1);
                4: thr = PRIO_W'($urandom);
                default: thr = PRIO_W'($urandom_range(0, 400));
            endcase
            write_threshold(thr);
            base_a     = PRIO_W'($urandom);
            base_b     = PRIO_W'($urandom_range(0, 300));
            style      = (phase == 0) ? 0 : $urandom_range(0, 2);
            submit_pct = (style == 0) ? 85 : (style == 1) ? 30 : 55;
            steady     = (phase == 5);
            quota      = $urandom_range(60, 120);
            repeat (quota) begin
                if ($urandom_range(0, 99) < 2) begin
                    settle();
                end
                if ($urandom_range(0, 99) < submit_pct) begin
                    send_item(CMD_SUBMIT, ID_W'($urandom), pick_priority(thr, base_a, base_b),
                              1'b0, R_PRED);
                end else begin
                    send_item(CMD_DEQUEUE, ID_W'($urandom), 16'($urandom), 1'b0, R_PRED);
                end
                done_items++;
            end
            steady = 1'b0;
            phase++;
        end
        settle();

        $display("run: %0d transactions in, %0d results out, %0d threshold writes, %0d phases",
                 n_in, n_out, n_cfg, phase);
        $display("mix: high %0d, low %0d, negative %0d, full %0d, dequeued %0d, empty %0d",
                 tally[0], tally[1], tally[2], tally[3], tally[4], tally[5]);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/tcpq_pkg.sv
design/tcpq_ram.sv
design/tcpq_ctrl.sv
design/tcpq_dp.sv
design/two_class_priority_job_queue.sv
tb/testbench.sv
